// ===== sv/sem_pkg.sv =====
`timescale 1ns / 1ps

package sem_pkg;

    // register indexes of the configuration port
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam int CFG_DATA_W = 16;

    localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;
    localparam logic [15:0] MIN_HEIGHT         = 16'd3;

    localparam logic [7:0] MAG_MAX = 8'd255;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // square root pipeline: two bit steps per stage over a 16-bit radicand
    localparam int SQRT_STAGES = 4;

    typedef struct packed {
        logic [11:0] image_width;
        logic [15:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic signed [10:0] gv;
        logic signed [10:0] gh;
        logic               frame_last;
    } grad_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } queue_status_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] root;
    } sqrt_state_t;

    // a + 2b + c of one kernel column or row
    function automatic logic signed [10:0] wsum(input logic [7:0] a,
                                                 input logic [7:0] b,
                                                 input logic [7:0] c);
        logic signed [10:0] ea;
        logic signed [10:0] eb;
        logic signed [10:0] ec;
        ea = $signed({3'b000, a});
        eb = $signed({2'b00, b, 1'b0});
        ec = $signed({3'b000, c});
        return ea + eb + ec;
    endfunction

    // one digit step of the restoring integer square root
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t st,
                                              input logic [15:0] bit_val);
        sqrt_state_t res;
        logic [16:0] trial;
        trial = {1'b0, st.root} + {1'b0, bit_val};
        if ({1'b0, st.rem} >= trial) begin
            res.rem  = st.rem - trial[15:0];
            res.root = (st.root >> 1) + bit_val;
        end else begin
            res.rem  = st.rem;
            res.root = st.root >> 1;
        end
        return res;
    endfunction

endpackage

// ===== sv/sem_queue.sv =====
`timescale 1ns / 1ps

module sem_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  sem_pkg::grad_t         push_data,
    input  logic                   pop,
    output sem_pkg::grad_t         head,
    output sem_pkg::queue_status_t status
);
    import sem_pkg::*;

    grad_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full))
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && status.empty))
        else $error("request popped from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

// ===== sv/sem_front.sv =====
`timescale 1ns / 1ps

module sem_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sem_pkg::cfg_t         cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_pixel_value,
    input  sem_pkg::queue_status_t q_status,
    output logic                  push,
    output sem_pkg::grad_t        push_data
);
    import sem_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > 12) ? COL_W + 1 : 12;

    // raster position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [15:0]      row_reg;
    logic [15:0]      row_next;

    // second stage, where line data is back from memory
    logic             b_valid_reg;
    logic [7:0]       b_px_reg;
    logic [COL_W-1:0] b_col_reg;
    logic             b_emit_reg;
    logic             b_last_reg;

    logic [15:0]      line_mem [MAX_WIDTH];
    logic [15:0]      rd_data_reg;
    logic [7:0]       win_reg [6];

    logic             accept;
    logic [CMP_W-1:0] width_ext;
    logic [CMP_W-1:0] width_use;
    logic [CMP_W-1:0] col_plus;
    logic [15:0]      height_use;
    logic [16:0]      row_plus;
    logic             row_end;
    logic             frame_end;
    logic             emit;
    logic [7:0]       top;
    logic [7:0]       mid;
    logic [QCNT_W:0]  pending;

    // room for the request in the second stage and for the one now taken
    assign pending = {1'b0, q_status.count} + {{QCNT_W{1'b0}}, b_valid_reg};
    assign s_ready = (pending < (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept  = s_valid && s_ready;

    // classify the position of the incoming pixel
    always_comb begin
        width_ext = CMP_W'(cfg.image_width);
        if (width_ext < CMP_W'(3)) begin
            width_use = CMP_W'(3);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_use = CMP_W'(MAX_WIDTH);
        end else begin
            width_use = width_ext;
        end
        height_use = (cfg.image_height < MIN_HEIGHT) ? MIN_HEIGHT : cfg.image_height;
        col_plus   = CMP_W'(col_reg) + CMP_W'(1);
        row_plus   = {1'b0, row_reg} + 17'd1;
        row_end    = (col_plus >= width_use);
        frame_end  = row_end && (row_plus >= {1'b0, height_use});
        emit       = (row_reg >= 16'd2) && (col_reg >= COL_W'(2));
    end

    // next position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = frame_end ? 16'd0 : row_plus[15:0];
            end else begin
                col_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_px_reg   <= s_pixel_value;
            b_col_reg  <= col_reg;
            b_emit_reg <= emit;
            b_last_reg <= frame_end;
        end
    end

    // line stores: two rows above packed in one word, read at accept, written the cycle after
    assign top = rd_data_reg[15:8];
    assign mid = rd_data_reg[7:0];

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (b_valid_reg) begin
            line_mem[b_col_reg] <= {mid, b_px_reg};
        end
    end

    // window of the two previous columns
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (b_valid_reg) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= b_px_reg;
        end
    end

    // vertical and horizontal kernel sums
    always_comb begin
        push_data.gv = wsum(win_reg[0], win_reg[3], top)
                     - wsum(win_reg[2], win_reg[5], b_px_reg);
        push_data.gh = wsum(top, mid, b_px_reg)
                     - wsum(win_reg[0], win_reg[1], win_reg[2]);
        push_data.frame_last = b_last_reg;
    end

    assign push = b_valid_reg && b_emit_reg;

endmodule

// ===== sv/sem_back.sv =====
`timescale 1ns / 1ps

module sem_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  sem_pkg::grad_t head,
    input  logic           q_empty,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_edge_magnitude,
    output logic           m_frame_last
);
    import sem_pkg::*;

    logic        advance;

    // squares
    logic        sq_valid_reg;
    logic [19:0] sq_v_reg;
    logic [19:0] sq_h_reg;
    logic        sq_last_reg;
    logic signed [21:0] prod_v;
    logic signed [21:0] prod_h;
    logic [20:0] sum;

    // square root stages, index 0 holds the radicand
    logic        st_valid_reg [SQRT_STAGES+1];
    sqrt_state_t st_reg       [SQRT_STAGES+1];
    logic        st_sat_reg   [SQRT_STAGES+1];
    logic        st_last_reg  [SQRT_STAGES+1];
    sqrt_state_t st_next      [SQRT_STAGES+1];

    logic        m_valid_reg;
    logic [7:0]  mag_reg;
    logic        last_reg;

    // whole pipeline moves when the output slot is free or being taken
    assign advance = !m_valid_reg || m_ready;
    assign pop     = advance && !q_empty;

    assign prod_v = head.gv * head.gv;
    assign prod_h = head.gh * head.gh;
    assign sum    = {1'b0, sq_v_reg} + {1'b0, sq_h_reg};

    // two root digits per stage
    always_comb begin
        sqrt_state_t tmp;
        st_next[0] = st_reg[0];
        for (int s = 1; s <= SQRT_STAGES; s++) begin
            tmp        = sqrt_step(st_reg[s-1], 16'd1 << (18 - 4 * s));
            st_next[s] = sqrt_step(tmp, 16'd1 << (16 - 4 * s));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
            for (int s = 0; s <= SQRT_STAGES; s++) begin
                st_valid_reg[s] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            sq_valid_reg    <= pop;
            st_valid_reg[0] <= sq_valid_reg;
            for (int s = 1; s <= SQRT_STAGES; s++) begin
                st_valid_reg[s] <= st_valid_reg[s-1];
            end
            m_valid_reg <= st_valid_reg[SQRT_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sq_v_reg    <= prod_v[19:0];
            sq_h_reg    <= prod_h[19:0];
            sq_last_reg <= head.frame_last;

            // anything at or above 256 squared saturates
            st_reg[0].rem  <= sum[15:0];
            st_reg[0].root <= '0;
            st_sat_reg[0]  <= (sum[20:16] != 5'd0);
            st_last_reg[0] <= sq_last_reg;
            for (int s = 1; s <= SQRT_STAGES; s++) begin
                st_reg[s]      <= st_next[s];
                st_sat_reg[s]  <= st_sat_reg[s-1];
                st_last_reg[s] <= st_last_reg[s-1];
            end

            mag_reg  <= st_sat_reg[SQRT_STAGES] ? MAG_MAX : st_reg[SQRT_STAGES].root[7:0];
            last_reg <= st_last_reg[SQRT_STAGES];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_edge_magnitude = mag_reg;
    assign m_frame_last     = last_reg;

endmodule

// ===== sv/sobel_edge_magnitude_3x3.sv =====
// Streaming 3x3 Sobel edge magnitude over an 8-bit gray raster stream. The block takes
// one pixel per clock sustained while m_ready keeps up and gives one result for every
// interior pixel, the clamped floor square root of gv^2 + gh^2, with m_frame_last on the
// last result of a frame; border pixels give nothing. The front stage counts the raster
// position and reads the two rows above from one line memory of MAX_WIDTH words (one
// read and one write per cycle, read registered), then forms the kernel sums; a four-entry
// request queue feeds the back stage, which squares, adds and extracts the root two
// digits per stage. The line memory needs no clearing: stale words are read only in the
// first two rows of a frame, which give no result. Width and height are to be written
// through the cfg port only while the stream is idle, which the block does not enforce;
// they take effect at once. The width is held to 3..MAX_WIDTH and the height to >= 3.
`timescale 1ns / 1ps

module sobel_edge_magnitude_3x3 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_pixel_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_edge_magnitude,
    output logic                            m_frame_last
);
    import sem_pkg::*;

    cfg_t          cfg_reg;
    grad_t         push_data;
    grad_t         head;
    queue_status_t q_status;
    logic          push;
    logic          pop;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= IMAGE_WIDTH_RESET;
            cfg_reg.image_height <= IMAGE_HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[11:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    sem_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_value(s_pixel_value),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    sem_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    sem_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .q_empty         (q_status.empty),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_edge_magnitude(m_edge_magnitude),
        .m_frame_last    (m_frame_last)
    );

endmodule

// ===== dv/sobel_edge_magnitude_3x3_tb.sv =====
`timescale 1ns / 1ps

// edge magnitude predictor and the queue of results still owed by the block
class sobel_scoreboard #(int LINE_DEPTH = 2048);

    typedef struct packed {
        logic [7:0] magnitude;
        logic       frame_last;
    } edge_result_t;

    logic [11:0]  width_reg;
    logic [15:0]  height_reg;
    logic [7:0]   line_above [LINE_DEPTH];
    logic [7:0]   line_two_above [LINE_DEPTH];
    logic [7:0]   window [6];
    logic [10:0]  column;
    logic [15:0]  row;
    edge_result_t pending_edges [$];
    int unsigned  errors;
    int unsigned  pixels;
    int unsigned  results;
    int unsigned  frames;
    int unsigned  writes;

    function new();
        width_reg  = sem_pkg::IMAGE_WIDTH_RESET;
        height_reg = sem_pkg::IMAGE_HEIGHT_RESET;
        foreach (line_above[i]) begin
            line_above[i]     = '0;
            line_two_above[i] = '0;
        end
        foreach (window[i]) window[i] = '0;
        column  = '0;
        row     = '0;
        errors  = 0;
        pixels  = 0;
        results = 0;
        frames  = 0;
        writes  = 0;
    endfunction

    // width the block works with for a given register value
    function int unsigned width_for(logic [11:0] raw);
        if (raw < 3) return 3;
        if (raw > LINE_DEPTH) return LINE_DEPTH;
        return raw;
    endfunction

    function int unsigned width_in_use();
        return width_for(width_reg);
    endfunction

    function int unsigned height_in_use();
        return (height_reg < sem_pkg::MIN_HEIGHT) ? 3 : height_reg;
    endfunction

    function bit at_frame_start();
        return column == 0 && row == 0;
    endfunction

    // pixels still to come before the current frame closes
    function int unsigned pixels_to_frame_end();
        int unsigned w;
        int unsigned h;
        int unsigned cols_left;
        w = width_in_use();
        h = height_in_use();
        cols_left = (column + 1 >= w) ? 1 : w - column;
        if (row + 1 >= h) return cols_left;
        return cols_left + (h - 1 - row) * w;
    endfunction

    function void write_register(logic [sem_pkg::CFG_INDEX_W-1:0] index,
                                 logic [sem_pkg::CFG_DATA_W-1:0] data);
        writes++;
        case (index)
            sem_pkg::REG_IMAGE_WIDTH:  width_reg = data[11:0];
            sem_pkg::REG_IMAGE_HEIGHT: height_reg = data;
            default: ;
        endcase
    endfunction

    // integer floor square root, one result bit per pass
    function int unsigned floor_root(int unsigned v);
        int unsigned root;
        root = 0;
        for (int b = 11; b >= 0; b--) begin
            int unsigned trial;
            trial = root | (32'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // accepted pixel: advance the raster and queue the edge result it makes
    function void note_pixel(logic [7:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        logic [7:0]   top;
        logic [7:0]   mid;
        logic         row_end;
        logic         frame_end;
        int           l0, l1, l2, m0, m2, r0, r1, r2;
        int           gv;
        int           gh;
        int unsigned  root;
        edge_result_t res;

        w = width_in_use();
        h = height_in_use();
        c = column;
        r = row;
        top = line_two_above[c];
        mid = line_above[c];
        row_end   = (c + 1 >= w);
        frame_end = row_end && (r + 1 >= h);

        // full neighborhood once two rows and two columns are behind us
        if (r >= 2 && c >= 2) begin
            l0 = window[0];
            l1 = window[1];
            l2 = window[2];
            m0 = window[3];
            m2 = window[5];
            r0 = top;
            r1 = mid;
            r2 = px;
            gv = (l0 + 2 * m0 + r0) - (l2 + 2 * m2 + r2);
            gh = (r0 + 2 * r1 + r2) - (l0 + 2 * l1 + l2);
            root = floor_root(gv * gv + gh * gh);
            res.magnitude  = (root > 255) ? sem_pkg::MAG_MAX : root[7:0];
            res.frame_last = frame_end;
            pending_edges.push_back(res);
        end

        // shift line stores and window
        line_two_above[c] = mid;
        line_above[c]     = px;
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = px;

        // raster position
        if (row_end) begin
            column = '0;
            row    = frame_end ? 16'd0 : 16'(r + 1);
        end else begin
            column = 11'(c + 1);
        end
        pixels++;
    endfunction

    // result taken from the block: compare with the oldest one owed
    function void check_edge(logic [7:0] magnitude, logic frame_last);
        edge_result_t want;
        results++;
        if (pending_edges.size() == 0) begin
            errors++;
            $display("%0t: unexpected edge result: expected none, actual magnitude %0d last %0b",
                     $time, magnitude, frame_last);
            return;
        end
        want = pending_edges.pop_front();
        if (want.frame_last) frames++;
        if (magnitude !== want.magnitude) begin
            errors++;
            $display("%0t: edge magnitude mismatch: expected %0d, actual %0d",
                     $time, want.magnitude, magnitude);
        end
        if (frame_last !== want.frame_last) begin
            errors++;
            $display("%0t: frame last mismatch: expected %0b, actual %0b",
                     $time, want.frame_last, frame_last);
        end
    endfunction

endclass

module sobel_edge_magnitude_3x3_tb;
    import sem_pkg::*;

    localparam int MAX_WIDTH      = 2048;
    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 10;
    localparam int LATENCY_SLACK  = 16;
    localparam int RANDOM_PIXELS  = 550;
    localparam int RUN_CAP        = 150;
    localparam int TIMEOUT_CYCLES = 1000000;

    // indexes past the register list, ignored by the block
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum {FILL_NOISE, FILL_SMOOTH, FILL_BINARY} fill_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_pixel_value = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [7:0]             m_edge_magnitude;
    logic                   m_frame_last;

    sobel_scoreboard #(MAX_WIDTH) sb;
    int send_calm = 0;
    int recv_calm = 0;

    sobel_edge_magnitude_3x3 #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_value   (s_pixel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_edge_magnitude(m_edge_magnitude),
        .m_frame_last    (m_frame_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // wait before the next request, with calm stretches of back-to-back traffic
    function automatic int draw_pause(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] next_fill(fill_t fill, inout int level);
        case (fill)
            FILL_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_SMOOTH: begin
                level += int'($urandom_range(0, 6)) - 3;
                if (level < 0) level = 0;
                if (level > 255) level = 255;
                return level[7:0];
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        int pause;
        pause = draw_pause(send_calm);
        if (pause > 0) begin
            s_valid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= px;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
    endtask

    task automatic send_run(input int count, input fill_t fill);
        int level;
        level = $urandom_range(0, 255);
        repeat (count) send_pixel(next_fill(fill, level));
    endtask

    // hold the stream until every owed result is out and the pipeline is empty
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_edges.size() != 0) @(posedge aclk);
        repeat (LATENCY_SLACK) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(index, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // result side: random stalls per request
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_pause(recv_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_edge(m_edge_magnitude, m_frame_last);
    end

    initial begin
        int          random_pixels;
        int          n;
        bit          wide_done;
        logic [11:0] new_width;
        logic [15:0] new_height;

        sb = new();
        random_pixels = 0;
        wide_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 4x3 frame with a hard vertical step, every magnitude clamps
        write_register(REG_IMAGE_WIDTH, 16'hF004);
        write_register(REG_IMAGE_HEIGHT, 16'h0000);
        write_register(REG_SPARE_2, 16'hFFFF);
        write_register(REG_SPARE_3, 16'h0000);
        repeat (3) begin
            send_pixel(8'd255);
            send_pixel(8'd255);
            send_pixel(8'd0);
            send_pixel(8'd0);
        end
        drain();

        // widest setting, then narrowed mid-row so the next column ends the row
        write_register(REG_IMAGE_WIDTH, 16'h0FFF);
        write_register(REG_IMAGE_HEIGHT, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_pixel(8'(i * 40));
        drain();
        write_register(REG_IMAGE_WIDTH, 16'd3);
        send_pixel(8'd7);
        send_pixel(8'd3);
        send_pixel(8'd9);
        send_pixel(8'd27);
        send_pixel(8'd90);
        send_pixel(8'd91);
        send_pixel(8'd92);
        drain();

        // height cut below the current row: this row closes the frame
        write_register(REG_IMAGE_HEIGHT, 16'd2);
        repeat (3) send_pixel(8'd128);

        // random frames, mostly whole ones
        while (random_pixels < RANDOM_PIXELS) begin
            // one frame wider than the usual runs
            if (!wide_done && random_pixels >= RANDOM_PIXELS / 3) begin
                drain();
                write_register(REG_IMAGE_HEIGHT, 16'd0);
                n = sb.pixels_to_frame_end();
                send_run(n, FILL_NOISE);
                random_pixels += n;
                drain();
                write_register(REG_IMAGE_WIDTH,
                               {4'($urandom), 12'($urandom_range(41, 64))});
                write_register(REG_IMAGE_HEIGHT, 16'd3);
                n = 3 * sb.width_in_use();
                send_run(n, fill_t'($urandom_range(0, 2)));
                random_pixels += n;
                drain();
                write_register(REG_IMAGE_WIDTH, 16'd5);
                wide_done = 1'b1;
                continue;
            end

            // pause and maybe change geometry
            if ($urandom_range(0, 2) == 0) begin
                drain();
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 9))
                        0:       new_width = 12'($urandom_range(0, 2));
                        1, 2:    new_width = 12'($urandom_range(13, 40));
                        default: new_width = 12'($urandom_range(3, 12));
                    endcase
                    case ($urandom_range(0, 9))
                        0:       new_height = 16'($urandom_range(0, 2));
                        1:       new_height = 16'hFFFF;
                        2:       new_height = 16'($urandom_range(9, 16));
                        default: new_height = 16'($urandom_range(3, 8));
                    endcase
                    // growing mid-frame would read columns never stored
                    if ($urandom_range(0, 2) != 1 &&
                        (sb.at_frame_start() ||
                         sb.width_for(new_width) <= sb.width_in_use()))
                        write_register(REG_IMAGE_WIDTH, {4'($urandom), new_width});
                    if ($urandom_range(0, 2) != 0)
                        write_register(REG_IMAGE_HEIGHT, new_height);
                end
            end

            if ($urandom_range(0, 4) < 3) n = sb.pixels_to_frame_end();
            else n = $urandom_range(1, 2 * sb.width_in_use());
            if (n > RUN_CAP) n = RUN_CAP;
            if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
            send_run(n, fill_t'($urandom_range(0, 2)));
            random_pixels += n;
        end

        drain();
        $display("covered %0d pixels, %0d edge results, %0d frame ends, %0d register writes",
                 sb.pixels, sb.results, sb.frames, sb.writes);
        $display("widths 3 to %0d, heights 3 to 65535, mid-frame cuts, %0d errors",
                 MAX_WIDTH, sb.errors);
        if (sb.errors == 0 && sb.pending_edges.size() == 0) begin
            $display("sobel_edge_magnitude_3x3 regression: pass");
        end else begin
            $display("sobel_edge_magnitude_3x3 regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("sobel_edge_magnitude_3x3 regression: fail");
        $finish;
    end

endmodule
